// ===== rtl/core/filled_circle_span_rasterizer_defines.svh =====
// Assertion macros for the filled circle span rasterizer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef FILLED_CIRCLE_SPAN_RASTERIZER_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define FCSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcsr assertion failed");

// next-cycle implication
`define FCSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcsr assertion failed");

`endif

// ===== rtl/core/fcsr_pkg.sv =====
// Types and widths shared by the filled circle span rasterizer modules.
// No dependencies.
package fcsr_pkg;

    localparam int COL_W = 7;
    localparam int ROW_W = 6;
    localparam int RAD_IN_W = 6;
    localparam int RAD_W = 5;
    localparam int ERR_W = 12;

    typedef struct packed {
        logic [COL_W-1:0]    center_x;
        logic [ROW_W-1:0]    center_y;
        logic [RAD_IN_W-1:0] radius;
        logic                color;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] top_row;
        logic [ROW_W-1:0] bottom_row;
        logic             fill_value;
        logic             visible;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic shrink;
        logic emit;
        logic emit_neg;
        logic last;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic shrink_ok;
        logic slot_free;
        logic off_zero;
        logic off_at_radius;
    } t_status;

endpackage

// ===== rtl/core/fcsr_ctrl.sv =====
// Sequencer for the filled circle span rasterizer.
// Depends on fcsr_pkg for command and status structs.
module fcsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fcsr_pkg::t_status i_status,
    output logic             o_in_ready,
    output fcsr_pkg::t_cmd   o_cmd
);
    import fcsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POS  = 3'b010,
        S_NEG  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_POS;
                end
            end
            S_POS: begin
                if (i_status.shrink_ok) begin
                    o_cmd.shrink = 1'b1;
                end else if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.off_zero) begin
                        o_cmd.last = i_status.off_at_radius;
                        if (i_status.off_at_radius) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end else begin
                        n_state = S_NEG;
                    end
                end
            end
            S_NEG: begin
                if (i_status.slot_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_neg = 1'b1;
                    o_cmd.last     = i_status.off_at_radius;
                    if (i_status.off_at_radius) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_POS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/fcsr_datapath.sv =====
// Datapath for the filled circle span rasterizer: command latch, midpoint
// error term, span clipping and the output register. Depends on fcsr_pkg.
module fcsr_datapath #(
    parameter int MAX_RADIUS    = 31,
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fcsr_pkg::t_in_item  i_in_item,
    input  fcsr_pkg::t_cmd      i_cmd,
    input  logic                i_out_ready,
    output fcsr_pkg::t_status   o_status,
    output logic                o_out_valid,
    output fcsr_pkg::t_out_item o_out_item
);
    import fcsr_pkg::*;

    localparam logic [RAD_W-1:0]    MAX_R   = RAD_W'(MAX_RADIUS);
    localparam logic signed [COL_W+1:0] SCR_W = (COL_W+2)'(SCREEN_WIDTH);
    localparam logic signed [ROW_W+1:0] ROW_MAX = (ROW_W+2)'(SCREEN_HEIGHT - 1);

    logic [COL_W-1:0]        r_cx;
    logic [ROW_W-1:0]        r_cy;
    logic [RAD_W-1:0]        r_rad;
    logic                    r_color;
    logic [RAD_W-1:0]        r_off;
    logic [RAD_W-1:0]        r_hh;
    logic signed [ERR_W-1:0] r_err;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [RAD_W-1:0]          sat_rad;
    logic [RAD_W-1:0]          hh_dec;
    logic signed [COL_W+1:0]   col_s;
    logic signed [ROW_W+1:0]   top_s;
    logic signed [ROW_W+1:0]   bot_s;
    logic                      vis;
    t_out_item                 span;

    assign sat_rad = (i_in_item.radius > {1'b0, MAX_R}) ? MAX_R : i_in_item.radius[RAD_W-1:0];
    assign hh_dec  = r_hh - 1'b1;

    assign o_status.shrink_ok     = (r_err > 0) && (r_hh != '0);
    assign o_status.slot_free     = !r_out_valid || i_out_ready;
    assign o_status.off_zero      = (r_off == '0);
    assign o_status.off_at_radius = (r_off == r_rad);

    always_comb begin
        if (i_cmd.emit_neg) begin
            col_s = $signed({2'b00, r_cx}) - $signed({4'b0000, r_off});
        end else begin
            col_s = $signed({2'b00, r_cx}) + $signed({4'b0000, r_off});
        end
        top_s = $signed({2'b00, r_cy}) - $signed({3'b000, r_hh});
        bot_s = $signed({2'b00, r_cy}) + $signed({3'b000, r_hh});
        vis   = (col_s >= 0) && (col_s < SCR_W);
        if (top_s < 0) begin
            top_s = '0;
        end
        if (top_s > ROW_MAX) begin
            top_s = ROW_MAX;
            vis   = 1'b0;
        end
        if (bot_s > ROW_MAX) begin
            bot_s = ROW_MAX;
        end
        span.column     = vis ? col_s[COL_W-1:0] : '0;
        span.top_row    = top_s[ROW_W-1:0];
        span.bottom_row = bot_s[ROW_W-1:0];
        span.fill_value = r_color;
        span.visible    = vis;
        span.last       = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_in_item.center_x;
            r_cy    <= i_in_item.center_y;
            r_rad   <= sat_rad;
            r_color <= i_in_item.color;
            r_off   <= '0;
            r_hh    <= sat_rad;
            r_err   <= '0;
        end else if (i_cmd.shrink) begin
            r_hh  <= hh_dec;
            r_err <= r_err - $signed({{(ERR_W-RAD_W-1){1'b0}}, hh_dec, 1'b1});
        end else if (i_cmd.step) begin
            r_off <= r_off + 1'b1;
            r_err <= r_err + $signed({{(ERR_W-RAD_W-1){1'b0}}, r_off, 1'b1});
        end
        if (i_cmd.emit) begin
            r_out <= span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/core/filled_circle_span_rasterizer.sv =====
// Filled circle span rasterizer. Each accepted command (center, radius,
// color) yields 2r+1 vertical spans, center column first, then +1, -1, +2,
// -2 and so on, the final one flagged last; radius saturates at MAX_RADIUS.
// The sequencer accepts the command, then emits one span per cycle into the
// single output register, except where a half-height decrement of the
// midpoint loop or an output stall holds it. A new command is taken as
// soon as the previous one has queued its last span.
// Depends on fcsr_pkg, fcsr_ctrl, fcsr_datapath and the assertion header.
`include "filled_circle_span_rasterizer_defines.svh"

module filled_circle_span_rasterizer #(
    parameter int MAX_RADIUS    = 31,
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fcsr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fcsr_pkg::t_out_item o_out_item
);
    import fcsr_pkg::*;

    t_cmd    cmd;
    t_status status;

    fcsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    fcsr_datapath #(
        .MAX_RADIUS    (MAX_RADIUS),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // busy after a transaction is taken
    `FCSR_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // a pending span that is not the last one means a command is in flight
    `FCSR_ASSERT_IMP(a_mid_span_busy, o_out_valid && !o_out_item.last, !o_in_ready)
    // skipped spans report column zero
    `FCSR_ASSERT_IMP(a_hidden_col_zero, o_out_valid && !o_out_item.visible,
        o_out_item.column == '0)

endmodule

// ===== verif/filled_circle_span_rasterizer_test.sv =====
// Self-checking testbench for the filled circle span rasterizer.
// Sends circle commands, predicts every span in order and checks each output transaction.
// Depends on fcsr_pkg and the filled_circle_span_rasterizer top level.
`timescale 1ns / 1ps

module filled_circle_span_rasterizer_test;
    import fcsr_pkg::*;

    localparam int MAX_RADIUS     = 31;
    localparam int SCREEN_WIDTH   = 128;
    localparam int SCREEN_HEIGHT  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_out_item pending_spans[$];
    bit        idle_on = 1'b1;
    int        stall_left = 0;
    int        quiet_cycles = 0;
    int        circles_drawn = 0;
    int        radii_saturated = 0;
    int        spans_checked = 0;
    int        hidden_spans = 0;
    int        span_errors = 0;

    filled_circle_span_rasterizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in_item circle_cmd(input int x, input int y, input int r,
                                            input int c);
        t_in_item cmd;
        cmd.center_x = x[COL_W-1:0];
        cmd.center_y = y[ROW_W-1:0];
        cmd.radius   = r[RAD_IN_W-1:0];
        cmd.color    = c[0];
        return cmd;
    endfunction

    // midpoint fill: center column, then +off / -off pairs, half height shrinking
    function automatic void predict_spans(input t_in_item cmd);
        int        r;
        int        off;
        int        half;
        int        err;
        int        side;
        int        col;
        int        top;
        int        bot;
        bit        vis;
        t_out_item span;
        r = cmd.radius;
        if (r > MAX_RADIUS) begin
            r = MAX_RADIUS;
            radii_saturated++;
        end
        half = r;
        err = 0;
        for (off = 0; off <= r; off++) begin
            for (side = 0; side < ((off == 0) ? 1 : 2); side++) begin
                col = (side == 0) ? int'(cmd.center_x) + off : int'(cmd.center_x) - off;
                top = int'(cmd.center_y) - half;
                bot = int'(cmd.center_y) + half;
                vis = (col >= 0) && (col < SCREEN_WIDTH);
                if (top < 0) top = 0;
                if (top > SCREEN_HEIGHT - 1) begin
                    top = SCREEN_HEIGHT - 1;
                    vis = 1'b0;
                end
                if (bot > SCREEN_HEIGHT - 1) bot = SCREEN_HEIGHT - 1;
                span.column     = vis ? col[COL_W-1:0] : '0;
                span.top_row    = top[ROW_W-1:0];
                span.bottom_row = bot[ROW_W-1:0];
                span.fill_value = cmd.color;
                span.visible    = vis;
                span.last       = (off == r) && (side == 1 || r == 0);
                pending_spans.push_back(span);
            end
            err += 2 * off + 1;
            while (err > 0 && half > 0) begin
                half--;
                err -= 2 * half + 1;
            end
        end
    endfunction

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_circle(input t_in_item cmd);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        predict_spans(cmd);
        circles_drawn++;
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        send_circle(circle_cmd(64, 32, 0, 1));
        send_circle(circle_cmd(0, 0, 0, 0));
        send_circle(circle_cmd(127, 63, 0, 1));
        send_circle(circle_cmd(64, 32, 1, 1));
        send_circle(circle_cmd(64, 32, 31, 1));
        send_circle(circle_cmd(64, 32, 32, 0));
        send_circle(circle_cmd(64, 32, 63, 1));
        send_circle(circle_cmd(0, 0, 31, 1));
        send_circle(circle_cmd(127, 63, 31, 0));
        send_circle(circle_cmd(3, 32, 10, 1));
        send_circle(circle_cmd(124, 32, 10, 1));
        send_circle(circle_cmd(64, 2, 20, 1));
        send_circle(circle_cmd(64, 61, 20, 0));
        send_circle(circle_cmd(85, 42, 21, 1));
        send_circle(circle_cmd(42, 21, 42, 0));
        send_circle(circle_cmd(1, 62, 2, 1));
    endtask

    task automatic send_random_circle();
        int x;
        int r;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) x = $urandom_range(0, 5);
        else if (pick < 4) x = $urandom_range(122, 127);
        else x = $urandom_range(0, 127);
        pick = $urandom_range(0, 9);
        if (pick < 7) r = $urandom_range(0, 8);
        else if (pick < 9) r = $urandom_range(9, 31);
        else r = $urandom_range(32, 63);
        send_circle(circle_cmd(x, $urandom_range(0, 63), r, $urandom_range(0, 1)));
    endtask

    task automatic test_random_circles(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_random_circle();
        end
    endtask

    task automatic test_back_to_back(input int count);
        int n;
        idle_on = 1'b0;
        for (n = 0; n < count; n++) send_random_circle();
        i_in_valid <= 1'b0;
    endtask

    // output side: random ready bursts and span checking
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            spans_checked++;
            if (pending_spans.size() == 0) begin
                span_errors++;
                if (span_errors <= 10)
                    $display("unexpected span: col %0d rows %0d..%0d fill %0d vis %0d last %0d",
                             o_out_item.column, o_out_item.top_row, o_out_item.bottom_row,
                             o_out_item.fill_value, o_out_item.visible, o_out_item.last);
            end else begin
                want = pending_spans.pop_front();
                if (!want.visible) hidden_spans++;
                if (o_out_item.column !== want.column || o_out_item.top_row !== want.top_row
                    || o_out_item.bottom_row !== want.bottom_row
                    || o_out_item.fill_value !== want.fill_value
                    || o_out_item.visible !== want.visible || o_out_item.last !== want.last) begin
                    span_errors++;
                    if (span_errors <= 10)
                        $display({"span mismatch: expected col %0d rows %0d..%0d fill %0d ",
                                  "vis %0d last %0d, got col %0d rows %0d..%0d fill %0d ",
                                  "vis %0d last %0d"},
                                 want.column, want.top_row, want.bottom_row,
                                 want.fill_value, want.visible, want.last,
                                 o_out_item.column, o_out_item.top_row, o_out_item.bottom_row,
                                 o_out_item.fill_value, o_out_item.visible, o_out_item.last);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_circles(175);
        test_back_to_back(20);
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d circles drawn (%0d with saturated radius), %0d spans checked",
                 circles_drawn, radii_saturated, spans_checked);
        $display("%0d hidden spans, %0d span mismatches", hidden_spans, span_errors);
        if (span_errors == 0 && pending_spans.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
